FILE: hdl/kabf_pkg.sv
// ----------------------------------------------------------------------------
// kabf_pkg: shared types and constants of the angle and bias filter
// Holds command codes, register indexes, formats, request types, saturation.
// ----------------------------------------------------------------------------
`default_nettype none
package kabf_pkg;

	localparam int ANGLE_WIDTH_DEF = 32;
	localparam int COV_WIDTH_DEF = 40;
	localparam int FRAC = 24;
	localparam int WORD_W = 32;
	localparam int CMD_W = 2;
	localparam int DT_W = 24;
	localparam int REG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_QA = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_QB = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RM = 2'd2;

	localparam logic [WORD_W-1:0] QA_RST = 32'd16777;
	localparam logic [WORD_W-1:0] QB_RST = 32'd50331;
	localparam logic [WORD_W-1:0] RM_RST = 32'd503316;

	localparam logic signed [63:0] DEG_HALF = 64'sd11796480;
	localparam logic signed [63:0] DEG_FULL = 64'sd23592960;

	// multiply request and result between the sequencer and the shared multiplier
	typedef struct packed {
		logic start;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic signed [63:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic start;
		logic signed [63:0] num;
		logic signed [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [63:0] q;
	} div_rsp_t;

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat(input logic signed [63:0] v,
		input int w);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (w >= 64) return v;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/kabf_mul.sv
// ----------------------------------------------------------------------------
// kabf_mul: shared fixed-point multiplier
// floor(a*b / 2^24) saturated to 64 bits, built from four 32x32 partial
// products issued one per cycle and accumulated.
// ----------------------------------------------------------------------------
`default_nettype none
module kabf_mul (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire kabf_pkg::mul_req_t req,
	output kabf_pkg::mul_rsp_t rsp
);

	logic [63:0] ua_q, ub_q;
	logic neg_q;
	logic [127:0] acc_q;
	logic [2:0] step_q;
	logic busy_q;
	logic [31:0] opa, opb;
	logic [63:0] pp_s1;
	logic [127:0] qv;
	logic [127:0] qfix;
	logic frac_nz;

	always_comb begin
		case (step_q[1:0])
			2'd0: begin opa = ua_q[31:0]; opb = ub_q[31:0]; end
			2'd1: begin opa = ua_q[31:0]; opb = ub_q[63:32]; end
			2'd2: begin opa = ua_q[63:32]; opb = ub_q[31:0]; end
			default: begin opa = ua_q[63:32]; opb = ub_q[63:32]; end
		endcase
	end

	always_comb begin
		frac_nz = |acc_q[kabf_pkg::FRAC-1:0];
		qv = acc_q >> kabf_pkg::FRAC;
		qfix = qv + ((neg_q && frac_nz) ? 128'd1 : 128'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			rsp.done <= 1'b0;
			rsp.p <= '0;
			ua_q <= '0;
			ub_q <= '0;
			neg_q <= 1'b0;
			acc_q <= '0;
			pp_s1 <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				ua_q <= req.a[63] ? 64'(-req.a) : 64'(req.a);
				ub_q <= req.b[63] ? 64'(-req.b) : 64'(req.b);
				neg_q <= req.a[63] ^ req.b[63];
				acc_q <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q <= 3'd3) pp_s1 <= opa * opb;
				// accumulate the product registered in the previous step
				case (step_q)
					3'd1: acc_q <= acc_q + 128'(pp_s1);
					3'd2: acc_q <= acc_q + (128'(pp_s1) << 32);
					3'd3: acc_q <= acc_q + (128'(pp_s1) << 32);
					3'd4: begin
						acc_q <= acc_q + (128'(pp_s1) << 64);
					end
					3'd5: begin
						busy_q <= 1'b0;
						rsp.done <= 1'b1;
						if (neg_q) begin
							if (qfix > 128'h8000_0000_0000_0000)
								rsp.p <= 64'sh8000_0000_0000_0000;
							else
								rsp.p <= 64'(-qfix[63:0]);
						end else begin
							if (qfix > 128'h7FFF_FFFF_FFFF_FFFF)
								rsp.p <= 64'sh7FFF_FFFF_FFFF_FFFF;
							else
								rsp.p <= qfix[63:0];
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/kabf_div.sv
// ----------------------------------------------------------------------------
// kabf_div: shared restoring divider
// (num * 2^24) / den truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module kabf_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire kabf_pkg::div_req_t req,
	output kabf_pkg::div_rsp_t rsp
);

	logic [127:0] num_q;
	logic [127:0] quo_q;
	logic [63:0] den_q;
	logic [64:0] rem_q;
	logic neg_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [64:0] rem_sh;
	logic ge;

	always_comb begin
		rem_sh = {rem_q[63:0], num_q[127]};
		ge = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			rsp.done <= 1'b0;
			rsp.q <= '0;
			num_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			neg_q <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				num_q <= 128'(req.num[63] ? 64'(-req.num) : 64'(req.num))
					<< kabf_pkg::FRAC;
				den_q <= req.den[63] ? 64'(-req.den) : 64'(req.den);
				neg_q <= req.num[63] ^ req.den[63];
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q <= num_q << 1;
				rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
				quo_q <= {quo_q[126:0], ge};
				// count stays at the last bit so the result step can see it
				if (cnt_q == 7'd127) busy_q <= 1'b0;
				else cnt_q <= cnt_q + 7'd1;
			end else if (cnt_q == 7'd127) begin
				cnt_q <= '0;
				rsp.done <= 1'b1;
				if (neg_q) begin
					if (quo_q >= 128'h8000_0000_0000_0000)
						rsp.q <= 64'sh8000_0000_0000_0000;
					else
						rsp.q <= 64'(-quo_q[63:0]);
				end else begin
					if (quo_q > 128'h7FFF_FFFF_FFFF_FFFF)
						rsp.q <= 64'sh7FFF_FFFF_FFFF_FFFF;
					else
						rsp.q <= quo_q[63:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/kalman_angle_bias_filter_unit.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_unit: two-state angle and gyro bias filter
// A sequencer steps one update through a shared multiplier and divider.
// ----------------------------------------------------------------------------
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    cmd, meas_angle, gyro_rate, time_step
// out       out   out_valid / out_ready  est_angle, est_rate, est_bias, div_fault
// cfg       in    cfg_we                 cfg_index, cfg_data
//
// an update runs ten multiplies and two divides; whole turns leave the innovation in
// ST_TURN and ST_WFIX, a zero innovation variance skips both divides, and other words
// go from acceptance straight to ST_OUT.
// the divider produces one quotient bit per cycle.
// in_ready is low from acceptance until the result word is taken.
// reset clears all state and loads the noise registers with their defaults.
`default_nettype none
module kalman_angle_bias_filter_unit #(
	parameter int ANGLE_WIDTH = kabf_pkg::ANGLE_WIDTH_DEF,
	parameter int COV_WIDTH = kabf_pkg::COV_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [1:0] cmd,
	input  wire logic signed [31:0] meas_angle,
	input  wire logic signed [31:0] gyro_rate,
	input  wire logic [23:0] time_step,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [31:0] est_angle,
	output logic signed [31:0] est_rate,
	output logic signed [31:0] est_bias,
	output logic div_fault,
	input  wire logic cfg_we,
	input  wire logic [kabf_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_D1, ST_D2, ST_WRAP,
		ST_TURN, ST_WFIX,
		ST_M6, ST_M7, ST_M8, ST_M9, ST_M10, ST_M11, ST_OUT
	} state_t;

	state_t state_q;
	logic [31:0] qa_q, qb_q, rm_q;
	logic signed [63:0] angle_q, bias_q, rate_q;
	logic signed [63:0] aa_q, ab_q, ba_q, bb_q;
	logic signed [63:0] meas_q, dt_q, t_q, s_q, k0_q, k1_q, y_q, p00_q, p01_q;
	logic fault_q;
	logic issued_q;
	logic wneg_q;
	logic [3:0] wcnt_q;
	kabf_pkg::mul_req_t mreq;
	kabf_pkg::mul_rsp_t mrsp;
	kabf_pkg::div_req_t dreq;
	kabf_pkg::div_rsp_t drsp;
	logic signed [63:0] m_a, m_b, d_n;
	logic m_go, d_go;
	logic signed [63:0] yraw;
	logic signed [63:0] turn_step;
	logic signed [63:0] p;

	kabf_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	kabf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign p = mrsp.p;
	assign mreq.start = m_go;
	assign mreq.a = m_a;
	assign mreq.b = m_b;
	assign dreq.start = d_go;
	assign dreq.num = d_n;
	assign dreq.den = s_q;
	assign yraw = kabf_pkg::ssub(meas_q, angle_q);
	assign turn_step = kabf_pkg::DEG_FULL <<< wcnt_q;
	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	// operand selection for the shared multiplier and divider
	always_comb begin
		m_a = dt_q;
		m_b = '0;
		d_n = aa_q;
		case (state_q)
			ST_M1: m_b = rate_q;
			ST_M2: m_b = bb_q;
			ST_M3: m_b = kabf_pkg::sadd(kabf_pkg::ssub(kabf_pkg::ssub(t_q, ab_q), ba_q),
				64'(qa_q));
			ST_M4: begin m_a = 64'(qb_q); m_b = dt_q; end
			ST_D2: d_n = ba_q;
			ST_M6: begin m_a = k0_q; m_b = y_q; end
			ST_M7: begin m_a = k1_q; m_b = y_q; end
			ST_M8: begin m_a = k0_q; m_b = p00_q; end
			ST_M9: begin m_a = k0_q; m_b = p01_q; end
			ST_M10: begin m_a = k1_q; m_b = p00_q; end
			ST_M11: begin m_a = k1_q; m_b = p01_q; end
			default: ;
		endcase
		m_go = !issued_q && (state_q == ST_M1 || state_q == ST_M2 || state_q == ST_M3 ||
			state_q == ST_M4 || state_q == ST_M6 || state_q == ST_M7 ||
			state_q == ST_M8 || state_q == ST_M9 || state_q == ST_M10 ||
			state_q == ST_M11);
		d_go = !issued_q && (state_q == ST_D1 || state_q == ST_D2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			qa_q <= kabf_pkg::QA_RST;
			qb_q <= kabf_pkg::QB_RST;
			rm_q <= kabf_pkg::RM_RST;
			angle_q <= '0; bias_q <= '0; rate_q <= '0;
			aa_q <= '0; ab_q <= '0; ba_q <= '0; bb_q <= '0;
			out_valid <= 1'b0;
			issued_q <= 1'b0;
			fault_q <= 1'b0;
			wneg_q <= 1'b0;
			wcnt_q <= '0;
			meas_q <= '0; dt_q <= '0; t_q <= '0; s_q <= '0;
			k0_q <= '0; k1_q <= '0; y_q <= '0; p00_q <= '0; p01_q <= '0;
			est_angle <= '0; est_rate <= '0; est_bias <= '0; div_fault <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kabf_pkg::REG_QA: qa_q <= cfg_data;
					kabf_pkg::REG_QB: qb_q <= cfg_data;
					kabf_pkg::REG_RM: rm_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (m_go || d_go) issued_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						meas_q <= 64'(meas_angle);
						dt_q <= 64'(time_step);
						fault_q <= 1'b0;
						issued_q <= 1'b0;
						state_q <= ST_OUT;
						case (cmd)
							kabf_pkg::CMD_RESTART: begin
								angle_q <= '0; bias_q <= '0; rate_q <= '0;
								aa_q <= '0; ab_q <= '0; ba_q <= '0; bb_q <= '0;
							end
							kabf_pkg::CMD_SET:
								angle_q <= kabf_pkg::sat(64'(meas_angle), ANGLE_WIDTH);
							kabf_pkg::CMD_UPDATE: begin
								if (time_step != '0) begin
									rate_q <= kabf_pkg::sat(kabf_pkg::ssub(64'(gyro_rate),
										bias_q), ANGLE_WIDTH);
									state_q <= ST_M1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_M1: if (mrsp.done) begin
					angle_q <= kabf_pkg::sat(kabf_pkg::sadd(angle_q, p), ANGLE_WIDTH);
					issued_q <= 1'b0; state_q <= ST_M2;
				end
				ST_M2: if (mrsp.done) begin
					t_q <= p; issued_q <= 1'b0; state_q <= ST_M3;
				end
				ST_M3: if (mrsp.done) begin
					aa_q <= kabf_pkg::sat(kabf_pkg::sadd(aa_q, p), COV_WIDTH);
					ab_q <= kabf_pkg::sat(kabf_pkg::ssub(ab_q, t_q), COV_WIDTH);
					ba_q <= kabf_pkg::sat(kabf_pkg::ssub(ba_q, t_q), COV_WIDTH);
					issued_q <= 1'b0; state_q <= ST_M4;
				end
				ST_M4: if (mrsp.done) begin
					bb_q <= kabf_pkg::sat(kabf_pkg::sadd(bb_q, p), COV_WIDTH);
					s_q <= kabf_pkg::sadd(aa_q, 64'(rm_q));
					issued_q <= 1'b0; state_q <= ST_M5;
				end
				ST_M5: begin
					// zero innovation variance skips both divides
					if (s_q == '0) begin
						k0_q <= '0; k1_q <= '0; fault_q <= 1'b1; state_q <= ST_WRAP;
					end else begin
						state_q <= ST_D1;
					end
					issued_q <= 1'b0;
				end
				ST_D1: if (drsp.done) begin
					k0_q <= kabf_pkg::sat(drsp.q, COV_WIDTH);
					issued_q <= 1'b0; state_q <= ST_D2;
				end
				ST_D2: if (drsp.done) begin
					k1_q <= kabf_pkg::sat(drsp.q, COV_WIDTH);
					issued_q <= 1'b0; state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					p00_q <= aa_q; p01_q <= ab_q;
					issued_q <= 1'b0;
					wcnt_q <= 4'd8;
					// distance past the edge, turns removed below
					if (yraw > kabf_pkg::DEG_HALF) begin
						y_q <= yraw - kabf_pkg::DEG_HALF;
						wneg_q <= 1'b0;
						state_q <= ST_TURN;
					end else if (yraw < -kabf_pkg::DEG_HALF) begin
						y_q <= -kabf_pkg::DEG_HALF - yraw;
						wneg_q <= 1'b1;
						state_q <= ST_TURN;
					end else begin
						y_q <= yraw;
						state_q <= ST_M6;
					end
				end
				ST_TURN: begin
					// remove whole turns, largest power-of-two multiple first
					if (y_q >= turn_step) y_q <= y_q - turn_step;
					wcnt_q <= wcnt_q - 4'd1;
					if (wcnt_q == '0) state_q <= ST_WFIX;
				end
				ST_WFIX: begin
					// an exact number of turns lands on the edge itself
					if (y_q == '0)
						y_q <= wneg_q ? -kabf_pkg::DEG_HALF : kabf_pkg::DEG_HALF;
					else
						y_q <= wneg_q ? kabf_pkg::DEG_HALF - y_q : y_q - kabf_pkg::DEG_HALF;
					state_q <= ST_M6;
				end
				ST_M6: if (mrsp.done) begin
					angle_q <= kabf_pkg::sat(kabf_pkg::sadd(angle_q, p), ANGLE_WIDTH);
					issued_q <= 1'b0; state_q <= ST_M7;
				end
				ST_M7: if (mrsp.done) begin
					bias_q <= kabf_pkg::sat(kabf_pkg::sadd(bias_q, p), ANGLE_WIDTH);
					issued_q <= 1'b0; state_q <= ST_M8;
				end
				ST_M8: if (mrsp.done) begin
					aa_q <= kabf_pkg::sat(kabf_pkg::ssub(aa_q, p), COV_WIDTH);
					issued_q <= 1'b0; state_q <= ST_M9;
				end
				ST_M9: if (mrsp.done) begin
					ab_q <= kabf_pkg::sat(kabf_pkg::ssub(ab_q, p), COV_WIDTH);
					issued_q <= 1'b0; state_q <= ST_M10;
				end
				ST_M10: if (mrsp.done) begin
					ba_q <= kabf_pkg::sat(kabf_pkg::ssub(ba_q, p), COV_WIDTH);
					issued_q <= 1'b0; state_q <= ST_M11;
				end
				ST_M11: if (mrsp.done) begin
					bb_q <= kabf_pkg::sat(kabf_pkg::ssub(bb_q, p), COV_WIDTH);
					issued_q <= 1'b0; state_q <= ST_OUT;
				end
				ST_OUT: begin
					est_angle <= 32'(kabf_pkg::sat(angle_q, 32));
					est_rate <= 32'(kabf_pkg::sat(rate_q, 32));
					est_bias <= 32'(kabf_pkg::sat(bias_q, 32));
					div_fault <= fault_q;
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/kabf_checker.sv
// ----------------------------------------------------------------------------
// kabf_checker: port-level checks of the filter unit
// Watches handshakes and result words on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module kabf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic signed [31:0] est_angle,
	input wire logic div_fault
);

	// no new word while a result is pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while result pending");

	// a result follows acceptance, but not in the cycle after it
	a_noimm: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(est_angle)
		&& $stable(div_fault))) else $error("result dropped");

endmodule

bind kalman_angle_bias_filter_unit kabf_checker u_kabf_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .est_angle(est_angle),
	.div_fault(div_fault)
);
`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the angle and gyro bias filter
// Drives command words through the valid/ready input under several idle
// patterns, predicts each result word with a fixed-point filter model
// kept here, and compares every field of every result word in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [kabf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [kabf_pkg::CMD_W-1:0] cmd;
		logic signed [31:0] meas;
		logic signed [31:0] gyro;
		logic [kabf_pkg::DT_W-1:0] dt;
	} imu_word_t;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
		logic signed [31:0] bias;
		logic fault;
	} est_word_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] cmd;
	logic signed [31:0] meas_angle, gyro_rate;
	logic [23:0] time_step;
	logic signed [31:0] est_angle, est_rate, est_bias;
	logic div_fault;
	logic cfg_we;
	logic [kabf_pkg::REG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	kalman_angle_bias_filter_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .meas_angle(meas_angle), .gyro_rate(gyro_rate),
		.time_step(time_step),
		.out_valid(out_valid), .out_ready(out_ready),
		.est_angle(est_angle), .est_rate(est_rate), .est_bias(est_bias),
		.div_fault(div_fault),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	imu_word_t pending_words[$];
	est_word_t expected_ests[$];
	int sender_idle_pct, receiver_stall_pct;
	bit failed;
	bit in_took;
	int quiet_cycles;

	// filter model state and noise settings
	logic [31:0] noise_qa, noise_qb, noise_rm;
	longint f_angle, f_bias, f_rate, f_paa, f_pab, f_pba, f_pbb;

	function automatic longint clip(input logic signed [127:0] v, input int w);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< (w - 1)) - 128'sd1;
		lo = -hi - 128'sd1;
		if (v > hi) return longint'(hi);
		if (v < lo) return longint'(lo);
		return longint'(v);
	endfunction

	function automatic longint add_s(input longint a, input longint b);
		return clip(128'(a) + 128'(b), 64);
	endfunction

	function automatic longint sub_s(input longint a, input longint b);
		return clip(128'(a) - 128'(b), 64);
	endfunction

	// product with 24 fraction bits dropped, rounded down
	function automatic longint fx_mul(input longint a, input longint b);
		logic signed [127:0] p;
		p = 128'(a) * 128'(b);
		return clip(p >>> kabf_pkg::FRAC, 64);
	endfunction

	// quotient with 24 fraction bits, truncated toward zero
	function automatic longint fx_div(input longint n, input longint d);
		logic signed [127:0] q;
		q = (128'(n) <<< kabf_pkg::FRAC) / 128'(d);
		return clip(q, 64);
	endfunction

	function automatic longint wrap_turns(input longint y);
		longint half, full, n;
		half = 180 * 65536;
		full = 360 * 65536;
		if (y > half) begin
			n = (y - half + full - 1) / full;
			y = y - n * full;
		end else if (y < -half) begin
			n = (-half - y + full - 1) / full;
			y = y + n * full;
		end
		return y;
	endfunction

	function automatic est_word_t filter_step(input imu_word_t w);
		est_word_t e;
		longint dt, t, inner, s, k0, k1, y, p00, p01, qa, qb, rm;
		bit flt;
		flt = 0;
		dt = longint'({40'd0, w.dt});
		qa = longint'({32'd0, noise_qa});
		qb = longint'({32'd0, noise_qb});
		rm = longint'({32'd0, noise_rm});
		if (w.cmd == kabf_pkg::CMD_RESTART) begin
			f_angle = 0; f_bias = 0; f_rate = 0;
			f_paa = 0; f_pab = 0; f_pba = 0; f_pbb = 0;
		end else if (w.cmd == kabf_pkg::CMD_SET) begin
			f_angle = longint'(w.meas);
		end else if (w.cmd == kabf_pkg::CMD_UPDATE && dt != 0) begin
			f_rate = clip(sub_s(longint'(w.gyro), f_bias), 32);
			f_angle = clip(add_s(f_angle, fx_mul(dt, f_rate)), 32);
			t = fx_mul(dt, f_pbb);
			inner = add_s(sub_s(sub_s(t, f_pab), f_pba), qa);
			f_paa = clip(add_s(f_paa, fx_mul(dt, inner)), 40);
			f_pab = clip(sub_s(f_pab, t), 40);
			f_pba = clip(sub_s(f_pba, t), 40);
			f_pbb = clip(add_s(f_pbb, fx_mul(qb, dt)), 40);
			s = add_s(f_paa, rm);
			if (s == 0) begin
				k0 = 0;
				k1 = 0;
				flt = 1;
			end else begin
				k0 = clip(fx_div(f_paa, s), 40);
				k1 = clip(fx_div(f_pba, s), 40);
			end
			y = wrap_turns(sub_s(longint'(w.meas), f_angle));
			f_angle = clip(add_s(f_angle, fx_mul(k0, y)), 32);
			f_bias = clip(add_s(f_bias, fx_mul(k1, y)), 32);
			p00 = f_paa;
			p01 = f_pab;
			f_paa = clip(sub_s(f_paa, fx_mul(k0, p00)), 40);
			f_pab = clip(sub_s(f_pab, fx_mul(k0, p01)), 40);
			f_pba = clip(sub_s(f_pba, fx_mul(k1, p00)), 40);
			f_pbb = clip(sub_s(f_pbb, fx_mul(k1, p01)), 40);
		end
		e.angle = f_angle[31:0];
		e.rate = f_rate[31:0];
		e.bias = f_bias[31:0];
		e.fault = flt;
		return e;
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// driver: inputs move on the falling edge
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				imu_word_t w;
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				cmd <= w.cmd;
				meas_angle <= w.meas;
				gyro_rate <= w.gyro;
				time_step <= w.dt;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// monitor: predict on input words, check output words, watch for hangs
	always @(posedge clk) begin
		in_took = in_valid && in_ready;
		if (in_took)
			expected_ests.push_back(filter_step({cmd, meas_angle, gyro_rate, time_step}));
		if (out_valid && out_ready) begin
			if (expected_ests.size() == 0) begin
				$display("%0t: unexpected word angle=%0d rate=%0d bias=%0d fault=%0b",
					$time, est_angle, est_rate, est_bias, div_fault);
				failed = 1;
			end else begin
				est_word_t e;
				e = expected_ests.pop_front();
				if (e.angle !== est_angle) begin
					$display("%0t: est_angle expected %0d actual %0d", $time, e.angle, est_angle);
					failed = 1;
				end
				if (e.rate !== est_rate) begin
					$display("%0t: est_rate expected %0d actual %0d", $time, e.rate, est_rate);
					failed = 1;
				end
				if (e.bias !== est_bias) begin
					$display("%0t: est_bias expected %0d actual %0d", $time, e.bias, est_bias);
					failed = 1;
				end
				if (e.fault !== div_fault) begin
					$display("%0t: div_fault expected %0b actual %0b", $time, e.fault, div_fault);
					failed = 1;
				end
			end
		end
		if (in_took || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send(input logic [kabf_pkg::CMD_W-1:0] c, input logic [31:0] m,
		input logic [31:0] g, input logic [kabf_pkg::DT_W-1:0] d);
		pending_words.push_back({c, m, g, d});
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && !in_valid && expected_ests.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [kabf_pkg::REG_IDX_W-1:0] idx,
		input logic [31:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		case (idx)
			kabf_pkg::REG_QA: noise_qa = v;
			kabf_pkg::REG_QB: noise_qb = v;
			kabf_pkg::REG_RM: noise_rm = v;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_random(input int n);
		int r;
		logic [31:0] m, g;
		logic [kabf_pkg::DT_W-1:0] d;
		repeat (n) begin
			r = $urandom_range(99);
			m = $urandom();
			g = $urandom();
			d = kabf_pkg::DT_W'($urandom());
			// mostly plausible motion, some words over the full range
			if ($urandom_range(9) < 8) begin
				m = 32'($signed($urandom_range(800 * 65536)) - 400 * 65536);
				g = 32'($signed($urandom_range(400 * 65536)) - 200 * 65536);
				d = kabf_pkg::DT_W'($urandom_range(838861));
			end
			if (r < 85) send(kabf_pkg::CMD_UPDATE, m, g, d);
			else if (r < 91) send(kabf_pkg::CMD_SET, m, g, d);
			else if (r < 95) send(kabf_pkg::CMD_RESTART, m, g, d);
			else if (r < 98) send(CMD_UNUSED, m, g, d);
			else send(kabf_pkg::CMD_UPDATE, m, g, '0);
		end
	endtask

	initial begin
		failed = 0;
		in_took = 0;
		quiet_cycles = 0;
		in_valid = 0;
		out_ready = 0;
		cmd = '0;
		meas_angle = '0;
		gyro_rate = '0;
		time_step = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		noise_qa = kabf_pkg::QA_RST;
		noise_qb = kabf_pkg::QB_RST;
		noise_rm = kabf_pkg::RM_RST;
		f_angle = 0; f_bias = 0; f_rate = 0;
		f_paa = 0; f_pab = 0; f_pba = 0; f_pbb = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, every command, zero step, wrap of the innovation
		send(kabf_pkg::CMD_UPDATE, 32'sd10 * 65536, 32'sd5 * 65536, 24'd167772);
		send(kabf_pkg::CMD_UPDATE, 32'sd0, 32'sd0, 24'd0);
		send(kabf_pkg::CMD_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
		send(kabf_pkg::CMD_UPDATE, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF);
		send(kabf_pkg::CMD_SET, 32'sd170 * 65536, 32'h7FFF_FFFF, 24'h00_0001);
		send(kabf_pkg::CMD_UPDATE, -32'sd170 * 65536, 32'sd0, 24'd16777);
		send(kabf_pkg::CMD_SET, -32'sd170 * 65536, 32'sd0, 24'd0);
		send(kabf_pkg::CMD_UPDATE, 32'sd170 * 65536, 32'sd0, 24'd16777);
		send(kabf_pkg::CMD_SET, 32'sd0, 32'sd0, 24'd0);
		send(kabf_pkg::CMD_UPDATE, 32'sd180 * 65536, 32'sd0, 24'd1);
		send(kabf_pkg::CMD_UPDATE, -32'sd900 * 65536, 32'sd0, 24'd1);
		send(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
		send(kabf_pkg::CMD_SET, 32'h7FFF_FFFF, 32'sd0, 24'd0);
		send(kabf_pkg::CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
		send(kabf_pkg::CMD_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
		drain();

		// zero innovation variance
		write_reg(kabf_pkg::REG_QA, 32'd0);
		write_reg(kabf_pkg::REG_RM, 32'd0);
		send(kabf_pkg::CMD_RESTART, 32'sd0, 32'sd0, 24'd0);
		send(kabf_pkg::CMD_UPDATE, 32'sd45 * 65536, 32'sd3 * 65536, 24'd1677);
		send(kabf_pkg::CMD_UPDATE, 32'sd45 * 65536, 32'sd3 * 65536, 24'd1677);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
				1: begin sender_idle_pct = 87; receiver_stall_pct = 0; end
				2: begin sender_idle_pct = 0; receiver_stall_pct = 87; end
				default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
			endcase
			case (ph)
				0: begin
					write_reg(kabf_pkg::REG_QA, kabf_pkg::QA_RST);
					write_reg(kabf_pkg::REG_QB, kabf_pkg::QB_RST);
					write_reg(kabf_pkg::REG_RM, kabf_pkg::RM_RST);
				end
				1: begin
					write_reg(kabf_pkg::REG_QA, 32'hFFFF_FFFF);
					write_reg(kabf_pkg::REG_QB, 32'hFFFF_FFFF);
					write_reg(kabf_pkg::REG_RM, 32'hFFFF_FFFF);
				end
				2: begin
					write_reg(kabf_pkg::REG_QA, 32'd0);
					write_reg(kabf_pkg::REG_QB, 32'd0);
					write_reg(kabf_pkg::REG_RM, 32'd1);
				end
				default: begin
					write_reg(kabf_pkg::REG_QA, $urandom_range(1 << 22));
					write_reg(kabf_pkg::REG_QB, $urandom_range(1 << 22));
					write_reg(kabf_pkg::REG_RM, $urandom());
				end
			endcase
			send(kabf_pkg::CMD_RESTART, 32'sd0, 32'sd0, 24'd0);
			send_random(75);
			drain();
		end

		if (!failed) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
hdl/kabf_pkg.sv
hdl/kabf_mul.sv
hdl/kabf_div.sv
hdl/kalman_angle_bias_filter_unit.sv
hdl/kabf_checker.sv
sim/tb_top.sv
